@@ rtl/core/tlvmap_pkg.sv @@
// shared types and codes for the tlv option map allocator
// no dependencies; imported by the top level and its checker
package tlvmap_pkg;

  localparam logic [1:0] REQ_ADD  = 2'd0;
  localparam logic [1:0] REQ_DEL  = 2'd1;
  localparam logic [1:0] REQ_CLR  = 2'd2;
  localparam logic [1:0] REQ_FIND = 2'd3;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_MAPPED = 3'd1;
  localparam logic [2:0] ST_DUP   = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_BADLEN = 3'd4;

  // lengths in words never exceed the largest request, 255 bytes / 4
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned MAX_PIECES = 32;
  localparam int unsigned PIECE_W    = 5;

  typedef logic [23:0] key_t;

endpackage

@@ rtl/core/tlv_option_map_allocator_top.sv @@
// tlv option map allocator: slot table, free-word bitmap and run allocator
// depends on tlvmap_pkg
//
// usage:
//   requests enter on the in channel (in_valid_i / in_stall_o) and results
//   leave on the out channel (out_valid_o / out_stall_i); a transfer happens
//   when valid is high and stall is low.
//   one request is worked at a time; in_stall_o stays high until the final
//   result of the request is loaded into the output register.
//   add and find scan the slot keys one slot per cycle; each allocated
//   piece of an add then takes a scan of the free-word bitmap.
//   an add that allocates pieces gives one result per piece, the last one
//   flagged; every other request gives one result.
//   reset clears the slot valid bits and the bitmap at once; slot keys,
//   lengths and word masks are read only behind a valid bit.
//   while the receiver stalls, the output register holds its result and
//   the sequencer waits before loading the next one.
module tlv_option_map_allocator_top #(
  parameter int unsigned NUM_SLOTS   = 64,
  parameter int unsigned SPACE_WORDS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [5:0]  slot_index_i,
  input  logic [15:0] option_class_i,
  input  logic [7:0]  option_type_i,
  input  logic [7:0]  option_bytes_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        hit_o,
  output logic [5:0]  found_slot_o,
  output logic [7:0]  found_bytes_o,
  output logic [6:0]  piece_offset_o,
  output logic [7:0]  piece_bytes_o,
  output logic        last_o
);
  import tlvmap_pkg::*;

  localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned WW = (SPACE_WORDS > 1) ? $clog2(SPACE_WORDS) : 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_ALLOC  = 4'd3;
  localparam logic [3:0] S_COMMIT = 4'd4;
  localparam logic [3:0] S_DEL    = 4'd5;
  localparam logic [3:0] S_RESP   = 4'd6;
  localparam logic [3:0] S_EMIT   = 4'd7;

  logic [3:0] state_q, state_d;

  // request latch
  logic [1:0] req_q;
  logic [5:0] slot_q;
  key_t       key_q;
  logic [7:0] bytes_q;

  // slot table
  logic [NUM_SLOTS-1:0]   valid_q, valid_d;
  key_t                   key_mem   [NUM_SLOTS];
  logic [7:0]             bytes_mem [NUM_SLOTS];
  logic [SPACE_WORDS-1:0] words_mem [NUM_SLOTS];
  logic [SPACE_WORDS-1:0] used_q, used_d;

  // slot scan
  logic [SW:0]   ic_q, ic_d;
  logic          pend_q;
  logic [SW-1:0] ra_q;
  key_t          rk_q;
  logic [7:0]    rb_q;
  logic [SPACE_WORDS-1:0] rw_q;

  // allocator
  logic [SPACE_WORDS-1:0] work_q, work_d, taken_q, taken_d, run_mask;
  logic [LEN_W-1:0] remain_q, remain_d;
  logic [WW-1:0]    p_q, p_d, cur_start_q, cur_start_d, best_start_q, best_start_d;
  logic [LEN_W-1:0] cur_len_q, cur_len_d, best_len_q, best_len_d;
  logic [PIECE_W:0] n_q, n_d;
  logic [PIECE_W-1:0] rd_q, rd_d;
  logic [WW-1:0]    pb_start [MAX_PIECES];
  logic [LEN_W-1:0] pb_len   [MAX_PIECES];

  // single-result latch
  logic [2:0] rs_status_q, rs_status_d;
  logic       rs_hit_q, rs_hit_d;
  logic [5:0] rs_slot_q, rs_slot_d;
  logic [7:0] rs_bytes_q, rs_bytes_d;

  logic out_free, in_xfer, slot_ok, match, scan_done;
  logic free_w, at_end, fit, ending, upd_best, piece_go, piece_fail;
  logic [WW-1:0]    run_start, cand_start, nbest_start, pc_start;
  logic [LEN_W-1:0] nlen, cand_len, nbest_len, pc_len;
  logic             emit_last;
  logic [8:0]       emit_off;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_o || !out_stall_i;
  assign slot_ok    = {1'b0, slot_q} < 7'(NUM_SLOTS);
  assign match      = pend_q && valid_q[ra_q] && (rk_q == key_q);
  assign scan_done  = !pend_q && (ic_q == (SW+1)'(NUM_SLOTS));

  // one bitmap word per cycle
  assign free_w     = !work_q[p_q];
  assign at_end     = (p_q == WW'(SPACE_WORDS - 1));
  assign run_start  = (cur_len_q == '0) ? p_q : cur_start_q;
  assign nlen       = cur_len_q + LEN_W'(1);
  assign fit        = free_w && (nlen == remain_q);
  assign cand_len   = free_w ? nlen : cur_len_q;
  assign cand_start = free_w ? run_start : cur_start_q;
  assign ending     = !free_w || at_end;
  assign upd_best   = ending && (cand_len > best_len_q);
  assign nbest_len   = upd_best ? cand_len : best_len_q;
  assign nbest_start = upd_best ? cand_start : best_start_q;
  assign piece_go   = fit || (at_end && nbest_len != '0);
  assign piece_fail = !fit && at_end && nbest_len == '0;
  assign pc_start   = fit ? run_start : nbest_start;
  assign pc_len     = fit ? remain_q : nbest_len;

  always_comb begin
    for (int b = 0; b < SPACE_WORDS; b++) begin
      run_mask[b] = (7'(b) >= 7'(pc_start)) && (7'(b) < 7'(pc_start) + 7'(pc_len));
    end
  end

  assign emit_last = ({1'b0, rd_q} + (PIECE_W+1)'(1)) == n_q;
  assign emit_off  = 9'(pb_start[rd_q]) << 2;

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    used_d       = used_q;
    ic_d         = ic_q;
    work_d       = work_q;
    taken_d      = taken_q;
    remain_d     = remain_q;
    p_d          = p_q;
    cur_start_d  = cur_start_q;
    cur_len_d    = cur_len_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    n_d          = n_q;
    rd_d         = rd_q;
    rs_status_d  = rs_status_q;
    rs_hit_d     = rs_hit_q;
    rs_slot_d    = rs_slot_q;
    rs_bytes_d   = rs_bytes_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) state_d = S_DISP;
      end
      S_DISP: begin
        rs_status_d = ST_OK;
        rs_hit_d    = 1'b0;
        rs_slot_d   = '0;
        rs_bytes_d  = '0;
        ic_d        = '0;
        unique case (req_q)
          REQ_ADD: begin
            if (!slot_ok) begin
              rs_status_d = ST_FULL;
              state_d     = S_RESP;
            end else if (valid_q[slot_q[SW-1:0]]) begin
              rs_status_d = ST_MAPPED;
              state_d     = S_RESP;
            end else begin
              state_d = S_SCAN;
            end
          end
          REQ_DEL: begin
            if (slot_ok && valid_q[slot_q[SW-1:0]]) state_d = S_DEL;
            else state_d = S_RESP;
          end
          REQ_CLR: begin
            valid_d = '0;
            used_d  = '0;
            state_d = S_RESP;
          end
          REQ_FIND: state_d = S_SCAN;
          default: state_d = S_RESP;
        endcase
      end
      S_SCAN: begin
        if (match) begin
          if (req_q == REQ_ADD) begin
            rs_status_d = ST_DUP;
          end else begin
            rs_hit_d   = 1'b1;
            rs_slot_d  = 6'(ra_q);
            rs_bytes_d = rb_q;
          end
          state_d = S_RESP;
        end else if (scan_done) begin
          if (req_q != REQ_ADD) begin
            state_d = S_RESP;
          end else if (bytes_q[1:0] != 2'b00) begin
            rs_status_d = ST_BADLEN;
            state_d     = S_RESP;
          end else begin
            work_d       = used_q;
            taken_d      = '0;
            remain_d     = bytes_q[7:2];
            n_d          = '0;
            p_d          = '0;
            cur_len_d    = '0;
            cur_start_d  = '0;
            best_len_d   = '0;
            best_start_d = '0;
            state_d      = (bytes_q[7:2] == '0) ? S_COMMIT : S_ALLOC;
          end
        end
      end
      S_ALLOC: begin
        if (piece_go) begin
          work_d       = work_q | run_mask;
          taken_d      = taken_q | run_mask;
          remain_d     = remain_q - pc_len;
          n_d          = n_q + (PIECE_W+1)'(1);
          p_d          = '0;
          cur_len_d    = '0;
          best_len_d   = '0;
          best_start_d = '0;
          if (remain_q == pc_len) state_d = S_COMMIT;
        end else if (piece_fail) begin
          rs_status_d = ST_FULL;
          state_d     = S_RESP;
        end else begin
          p_d          = p_q + WW'(1);
          cur_len_d    = free_w ? nlen : '0;
          cur_start_d  = run_start;
          best_len_d   = nbest_len;
          best_start_d = nbest_start;
        end
      end
      S_COMMIT: begin
        used_d                   = work_q;
        valid_d[slot_q[SW-1:0]]  = 1'b1;
        rd_d                     = '0;
        state_d                  = (n_q == '0) ? S_RESP : S_EMIT;
      end
      S_DEL: begin
        used_d                  = used_q & ~rw_q;
        valid_d[slot_q[SW-1:0]] = 1'b0;
        state_d                 = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      S_EMIT: begin
        if (out_free) begin
          rd_d = rd_q + PIECE_W'(1);
          if (emit_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      used_q  <= '0;
      pend_q  <= 1'b0;
      ic_q    <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      used_q  <= used_d;
      if (state_q == S_SCAN && ic_q < (SW+1)'(NUM_SLOTS) && !match) begin
        pend_q <= 1'b1;
        ic_q   <= ic_q + (SW+1)'(1);
      end else begin
        pend_q <= 1'b0;
        ic_q   <= ic_d;
      end
      if ((state_q == S_RESP || state_q == S_EMIT) && out_free) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q   <= req_type_i;
      slot_q  <= slot_index_i;
      key_q   <= {option_class_i, option_type_i};
      bytes_q <= option_bytes_i;
    end
    work_q       <= work_d;
    taken_q      <= taken_d;
    remain_q     <= remain_d;
    p_q          <= p_d;
    cur_start_q  <= cur_start_d;
    cur_len_q    <= cur_len_d;
    best_start_q <= best_start_d;
    best_len_q   <= best_len_d;
    n_q          <= n_d;
    rd_q         <= rd_d;
    rs_status_q  <= rs_status_d;
    rs_hit_q     <= rs_hit_d;
    rs_slot_q    <= rs_slot_d;
    rs_bytes_q   <= rs_bytes_d;
  end

  // slot memories
  always_ff @(posedge clk_i) begin
    rk_q <= key_mem[ic_q[SW-1:0]];
    rb_q <= bytes_mem[ic_q[SW-1:0]];
    ra_q <= ic_q[SW-1:0];
    rw_q <= words_mem[slot_q[SW-1:0]];
    if (state_q == S_COMMIT) begin
      key_mem[slot_q[SW-1:0]]   <= key_q;
      bytes_mem[slot_q[SW-1:0]] <= bytes_q;
      words_mem[slot_q[SW-1:0]] <= taken_q;
    end
  end

  // piece buffer
  always_ff @(posedge clk_i) begin
    if (state_q == S_ALLOC && piece_go) begin
      pb_start[n_q[PIECE_W-1:0]] <= pc_start;
      pb_len[n_q[PIECE_W-1:0]]   <= pc_len;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (state_q == S_RESP) begin
        status_o       <= rs_status_q;
        hit_o          <= rs_hit_q;
        found_slot_o   <= rs_slot_q;
        found_bytes_o  <= rs_bytes_q;
        piece_offset_o <= '0;
        piece_bytes_o  <= '0;
        last_o         <= 1'b1;
      end else if (state_q == S_EMIT) begin
        status_o       <= ST_OK;
        hit_o          <= 1'b0;
        found_slot_o   <= '0;
        found_bytes_o  <= '0;
        piece_offset_o <= emit_off[6:0];
        piece_bytes_o  <= {pb_len[rd_q], 2'b00};
        last_o         <= emit_last;
      end
    end
  end

endmodule

@@ rtl/core/tlvmap_checker.sv @@
// port-level checks for the tlv option map allocator
// depends on tlvmap_pkg; bound to tlv_option_map_allocator_top
module tlvmap_sva (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] status_o,
  input logic       hit_o,
  input logic [5:0] found_slot_o,
  input logic [7:0] found_bytes_o,
  input logic       last_o
);
  import tlvmap_pkg::*;

  // a request keeps the block busy for at least the next cycle
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken right after a transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(last_o))
    else $error("stalled result changed");

  // only add pieces continue a request
  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> last_o)
    else $error("error result not final");

  a_hit_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> status_o == ST_OK && last_o)
    else $error("hit on a non-final or error result");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> found_slot_o == 6'd0 && found_bytes_o == 8'd0)
    else $error("found fields set without a hit");

endmodule

bind tlv_option_map_allocator_top tlvmap_sva u_tlvmap_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .hit_o         (hit_o),
  .found_slot_o  (found_slot_o),
  .found_bytes_o (found_bytes_o),
  .last_o        (last_o)
);
